### rtl/pid_controller_antiwindup_assert.svh
// Assertion helpers used by the controller module to check this block.
`ifndef PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH

// The consequent must hold at the same edge as the antecedent.
`define PIDAW_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define PIDAW_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pidaw_pkg.sv
`default_nettype none
package pidaw_pkg;

  localparam int DATA_W   = 32;
  localparam int IDX_W    = 3;
  localparam int PROD_W   = 2 * (DATA_W + 1);
  localparam int ACC_W    = 2 * DATA_W + 1;
  localparam int DVD_W    = 2 * DATA_W;
  localparam int CNT_W    = 5;

  localparam int SCALE_DIV   = 1000;
  localparam int RESET_LIMIT = 100000;

  localparam int DIV_STEPS_LONG  = DVD_W / 2;
  localparam int DIV_STEPS_SHORT = DATA_W / 2;

  localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_INT_LOW   = 3'd3,
    REG_INT_HIGH  = 3'd4,
    REG_OUT_LOW   = 3'd5,
    REG_OUT_HIGH  = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_D,
    S_MUL_I,
    S_CHK,
    S_DIV_I,
    S_SUM,
    S_DIV_O,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic long_op;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [DATA_W-1:0] abs_val(input logic signed [DATA_W-1:0] v);
    abs_val = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
  endfunction

endpackage
`default_nettype wire

### rtl/pidaw_in_if.sv
`default_nettype none
interface pidaw_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pidaw_pkg::DATA_W-1:0]   error_sample;

  modport source (output valid, output error_sample, input ready);
  modport sink (input valid, input error_sample, output ready);
endinterface
`default_nettype wire

### rtl/pidaw_out_if.sv
`default_nettype none
interface pidaw_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pidaw_pkg::DATA_W-1:0]   drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink (input valid, input drive_value, output ready);
endinterface
`default_nettype wire

### rtl/pidaw_cfg_if.sv
`default_nettype none
interface pidaw_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [pidaw_pkg::IDX_W-1:0]           idx;
  logic [pidaw_pkg::DATA_W-1:0]          data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface
`default_nettype wire

### rtl/pid_controller_antiwindup.sv
// PID controller with integral anti-windup, one drive word per error word.
// Error words are accepted only while idle, so a new word waits until the drive word
// of the last one is registered; pulling the integral back to a limit adds a divide.
// The shared radix-4 divider takes 32 steps for the 64-bit term sum over 1000 and
// 16 more for the back-calculation; an unread result holds the next one.
// Reset is synchronous, active low: gains zero, limits +/-100000, state zero.
`default_nettype none
`include "pid_controller_antiwindup_assert.svh"
module pid_controller_antiwindup (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pidaw_in_if.sink    in_ch,
  pidaw_out_if.source out_ch,
  pidaw_cfg_if.sink   cfg_ch
);

  localparam int W  = pidaw_pkg::DATA_W;
  localparam int PW = pidaw_pkg::PROD_W;
  localparam int AW = pidaw_pkg::ACC_W;
  localparam int DW = pidaw_pkg::DVD_W;

  pidaw_pkg::state_t state_r, state_nxt;

  logic signed [W-1:0]  kp_r, ki_r, kd_r;
  logic signed [W-1:0]  ilo_r, ihi_r, olo_r, ohi_r;

  logic signed [W-1:0]  err_r, err_nxt;
  logic signed [W:0]    dlt_r, dlt_nxt;
  logic signed [W-1:0]  integ_r, integ_nxt;
  logic signed [W-1:0]  last_r, last_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic                 bc_done_r, bc_done_nxt;
  logic                 q_neg_r, q_neg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [W-1:0]  out_data_r, out_data_nxt;

  logic signed [W:0]    mul_a, mul_b;
  logic signed [PW-1:0] prod;

  pidaw_pkg::div_ctrl_t div_ctrl;
  pidaw_pkg::div_stat_t div_stat;
  logic [DW-1:0]        div_dvd;
  logic [W-1:0]         div_dsr;
  logic [DW-1:0]        div_quo;

  logic signed [W:0]    isum;
  logic signed [AW-1:0] acc_mag;
  logic signed [AW-1:0] prod_t;
  logic [W-1:0]         bc_mag;
  logic signed [DW-1:0] res;

  pidaw_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pidaw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign cfg_ch.ready       = 1'b1;
  assign in_ch.ready        = (state_r == pidaw_pkg::S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_value = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= '0;
      ki_r  <= '0;
      kd_r  <= '0;
      ilo_r <= -W'(pidaw_pkg::RESET_LIMIT);
      ihi_r <= W'(pidaw_pkg::RESET_LIMIT);
      olo_r <= -W'(pidaw_pkg::RESET_LIMIT);
      ohi_r <= W'(pidaw_pkg::RESET_LIMIT);
    end else if (cfg_ch.valid) begin
      unique case (pidaw_pkg::cfg_idx_t'(cfg_ch.idx))
        pidaw_pkg::REG_GAIN_P:   kp_r  <= cfg_ch.data;
        pidaw_pkg::REG_GAIN_I:   ki_r  <= cfg_ch.data;
        pidaw_pkg::REG_GAIN_D:   kd_r  <= cfg_ch.data;
        pidaw_pkg::REG_INT_LOW:  ilo_r <= cfg_ch.data;
        pidaw_pkg::REG_INT_HIGH: ihi_r <= cfg_ch.data;
        pidaw_pkg::REG_OUT_LOW:  olo_r <= cfg_ch.data;
        pidaw_pkg::REG_OUT_HIGH: ohi_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pidaw_pkg::S_IDLE;
      integ_r     <= '0;
      last_r      <= '0;
      bc_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integ_r     <= integ_nxt;
      last_r      <= last_nxt;
      bc_done_r   <= bc_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    dlt_r      <= dlt_nxt;
    acc_r      <= acc_nxt;
    q_neg_r    <= q_neg_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    dlt_nxt       = dlt_r;
    integ_nxt     = integ_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    bc_done_nxt   = bc_done_r;
    q_neg_nxt     = q_neg_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;

    mul_a            = '0;
    mul_b            = '0;
    div_ctrl.start   = 1'b0;
    div_ctrl.long_op = 1'b0;
    div_dvd          = '0;
    div_dsr          = '0;

    isum    = (W+1)'(integ_r) + (W+1)'(in_ch.error_sample);
    prod_t  = prod[AW-1:0];
    acc_mag = acc_r[AW-1] ? -acc_r : acc_r;
    bc_mag  = div_quo[W-1:0];
    res     = q_neg_r ? -$signed(div_quo) : $signed(div_quo);

    unique case (state_r)
      pidaw_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          err_nxt  = in_ch.error_sample;
          dlt_nxt  = (W+1)'(in_ch.error_sample) - (W+1)'(last_r);
          last_nxt = in_ch.error_sample;
          // The running integral saturates at the 32-bit bounds.
          if (isum[W] != isum[W-1]) begin
            integ_nxt = isum[W] ? pidaw_pkg::INT_MIN : pidaw_pkg::INT_MAX;
          end else begin
            integ_nxt = isum[W-1:0];
          end
          bc_done_nxt = 1'b0;
          state_nxt   = pidaw_pkg::S_MUL_P;
        end
      end
      pidaw_pkg::S_MUL_P: begin
        mul_a     = (W+1)'(kp_r);
        mul_b     = (W+1)'(err_r);
        state_nxt = pidaw_pkg::S_MUL_D;
      end
      pidaw_pkg::S_MUL_D: begin
        mul_a     = (W+1)'(kd_r);
        mul_b     = dlt_r;
        acc_nxt   = prod_t;
        state_nxt = pidaw_pkg::S_MUL_I;
      end
      pidaw_pkg::S_MUL_I: begin
        mul_a = (W+1)'(ki_r);
        mul_b = (W+1)'(integ_r);
        // On the first pass the product is the derivative term; after a
        // back-calculation it comes from the idle multiplier and is dropped.
        if (!bc_done_r) begin
          acc_nxt = acc_r + prod_t;
        end
        state_nxt = pidaw_pkg::S_CHK;
      end
      pidaw_pkg::S_CHK: begin
        if (!bc_done_r && ki_r != '0 && prod > PW'(ihi_r)) begin
          div_ctrl.start = 1'b1;
          div_dvd        = {pidaw_pkg::abs_val(ihi_r), W'(0)};
          div_dsr        = pidaw_pkg::abs_val(ki_r);
          q_neg_nxt      = ihi_r[W-1] ^ ki_r[W-1];
          state_nxt      = pidaw_pkg::S_DIV_I;
        end else if (!bc_done_r && ki_r != '0 && prod < PW'(ilo_r)) begin
          div_ctrl.start = 1'b1;
          div_dvd        = {pidaw_pkg::abs_val(ilo_r), W'(0)};
          div_dsr        = pidaw_pkg::abs_val(ki_r);
          q_neg_nxt      = ilo_r[W-1] ^ ki_r[W-1];
          state_nxt      = pidaw_pkg::S_DIV_I;
        end else begin
          acc_nxt   = acc_r + prod_t;
          state_nxt = pidaw_pkg::S_SUM;
        end
      end
      pidaw_pkg::S_DIV_I: begin
        if (div_stat.done) begin
          // A positive quotient of 2^31 only arises from the most negative
          // limit over a gain of minus one; it saturates.
          if (q_neg_r) begin
            integ_nxt = -$signed(bc_mag);
          end else if (bc_mag[W-1]) begin
            integ_nxt = pidaw_pkg::INT_MAX;
          end else begin
            integ_nxt = $signed(bc_mag);
          end
          bc_done_nxt = 1'b1;
          state_nxt   = pidaw_pkg::S_MUL_I;
        end
      end
      pidaw_pkg::S_SUM: begin
        div_ctrl.start   = 1'b1;
        div_ctrl.long_op = 1'b1;
        div_dvd          = acc_mag[DW-1:0];
        div_dsr          = W'(pidaw_pkg::SCALE_DIV);
        q_neg_nxt        = acc_r[AW-1];
        state_nxt        = pidaw_pkg::S_DIV_O;
      end
      pidaw_pkg::S_DIV_O: begin
        if (div_stat.done) begin
          state_nxt = pidaw_pkg::S_OUT;
        end
      end
      pidaw_pkg::S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          // Low limit is tested first, so crossed limits favor the low one.
          if (res < DW'(olo_r)) begin
            out_data_nxt = olo_r;
          end else if (res > DW'(ohi_r)) begin
            out_data_nxt = ohi_r;
          end else begin
            out_data_nxt = res[W-1:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = pidaw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pidaw_pkg::S_IDLE;
      end
    endcase
  end

  `PIDAW_ASSERT_NOW(a_div_start_idle, clk, rst_n, div_ctrl.start, !div_stat.busy, "divider restarted while busy")
  `PIDAW_ASSERT_NOW(a_out_from_final, clk, rst_n, $rose(out_valid_r), $past(state_r == pidaw_pkg::S_OUT), "result raised outside the output step")
  `PIDAW_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_ch.valid && in_ch.ready, state_r == pidaw_pkg::S_MUL_P && !bc_done_r, "accepted word did not start the sequence")

endmodule
`default_nettype wire

### rtl/pidaw_mul.sv
`default_nettype none
module pidaw_mul (
  input  wire logic                                   clk,
  input  wire logic signed [pidaw_pkg::DATA_W:0]      a,
  input  wire logic signed [pidaw_pkg::DATA_W:0]      b,
  output logic signed [pidaw_pkg::PROD_W-1:0]         prod
);

  logic signed [pidaw_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

### rtl/pidaw_div.sv
`default_nettype none
module pidaw_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pidaw_pkg::div_ctrl_t              ctrl,
  input  wire logic [pidaw_pkg::DVD_W-1:0]       dividend,
  input  wire logic [pidaw_pkg::DATA_W-1:0]      divisor,
  output logic [pidaw_pkg::DVD_W-1:0]            quotient,
  output pidaw_pkg::div_stat_t                   stat
);

  localparam int W  = pidaw_pkg::DATA_W;
  localparam int DW = pidaw_pkg::DVD_W;

  logic                          busy_r;
  logic                          done_r;
  logic [pidaw_pkg::CNT_W-1:0]   cnt_r;
  logic [DW-1:0]                 dvd_r;
  logic [DW-1:0]                 quo_r;
  logic [W-1:0]                  rem_r;
  logic [W-1:0]                  d1_r;
  logic [W+1:0]                  d3_r;

  logic [W+1:0]                  rem4;
  logic [W+2:0]                  diff1;
  logic [W+2:0]                  diff2;
  logic [W+2:0]                  diff3;
  logic [1:0]                    qbits;
  logic [W-1:0]                  rem_nxt;

  // Radix-4 restoring step: two dividend bits enter the partial remainder
  // and are compared against one, two and three times the divisor at once.
  always_comb begin
    rem4  = {rem_r, dvd_r[DW-1 -: 2]};
    diff1 = {1'b0, rem4} - {3'b000, d1_r};
    diff2 = {1'b0, rem4} - {2'b00, d1_r, 1'b0};
    diff3 = {1'b0, rem4} - {1'b0, d3_r};
    if (!diff3[W+2]) begin
      qbits   = 2'd3;
      rem_nxt = diff3[W-1:0];
    end else if (!diff2[W+2]) begin
      qbits   = 2'd2;
      rem_nxt = diff2[W-1:0];
    end else if (!diff1[W+2]) begin
      qbits   = 2'd1;
      rem_nxt = diff1[W-1:0];
    end else begin
      qbits   = 2'd0;
      rem_nxt = rem4[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctrl.long_op ? pidaw_pkg::CNT_W'(pidaw_pkg::DIV_STEPS_LONG - 1)
                               : pidaw_pkg::CNT_W'(pidaw_pkg::DIV_STEPS_SHORT - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd_r <= dividend;
      quo_r <= '0;
      rem_r <= '0;
      d1_r  <= divisor;
      d3_r  <= {1'b0, divisor, 1'b0} + {2'b00, divisor};
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-3:0], 2'b00};
      quo_r <= {quo_r[DW-3:0], qbits};
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire
